FILE: rtl/cpc_pkg.sv
// Shared constants, types and helpers for the pulse combiner.
`default_nettype none

package cpc_pkg;

  localparam int MAX_GATES   = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int GATE_W     = $clog2(MAX_GATES + 1);
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 64;
  localparam int HALF_W     = ACC_W / 2;
  localparam int PART_W     = HALF_W + SAMPLE_BITS;
  localparam int PROD_W     = ACC_W + SAMPLE_BITS;
  localparam int OP_W       = 3;
  localparam int SPAN_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(4);

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_SUM  = 3'd0,
    OP_PROD = 3'd1,
    OP_MIN  = 3'd2,
    OP_MAX  = 3'd3,
    OP_AND  = 3'd4,
    OP_OR   = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMBINE_OP = 1'b0,
    CFG_CPI_SPAN   = 1'b1
  } cfg_idx_t;

  // One gate on its way through the fold pipe.
  typedef struct packed {
    logic [ADDR_W-1:0]              addr;
    op_t                            op;
    logic                           seed;
    logic                           emit;
    logic                           last;
    logic signed [SAMPLE_BITS-1:0]  sample;
  } item_t;

  // Write-back into the line store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    acc_t              data;
  } store_wr_t;

  // Unused codes fold as a sum.
  function automatic op_t decode_op(input logic [OP_W-1:0] code);
    op_t op;
    case (code)
      OP_PROD: op = OP_PROD;
      OP_MIN:  op = OP_MIN;
      OP_MAX:  op = OP_MAX;
      OP_AND:  op = OP_AND;
      OP_OR:   op = OP_OR;
      default: op = OP_SUM;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cpc_line_store.sv
// Per-gate accumulator memory: one write port, one registered read port.
`default_nettype none

module cpc_line_store (
  input  logic                       clk,
  input  cpc_pkg::store_wr_t         wr,
  input  logic                       rd_en,
  input  logic [cpc_pkg::ADDR_W-1:0] rd_addr,
  output cpc_pkg::acc_t              rd_data
);
  import cpc_pkg::*;

  acc_t mem [MAX_GATES];
  acc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/cpc_fold_pipe.sv
// Three-stage fold datapath with write-back and result register.
`default_nettype none

module cpc_fold_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ld,
  input  cpc_pkg::item_t             item,
  input  cpc_pkg::acc_t              rd_data,
  input  logic [cpc_pkg::ADDR_W-1:0] chk_addr,
  output logic                       chk_hit,
  output logic                       s1_free,
  output cpc_pkg::store_wr_t         wr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cpc_pkg::ACC_W-1:0]  out_combined,
  output logic                       out_last_gate
);
  import cpc_pkg::*;

  // stage 1: read data arrives, simple ops resolve, product operands prepared
  logic                    s1_v_r;
  item_t                   s1_r;
  // stage 2: partial products
  logic                    s2_v_r;
  item_t                   s2_r;
  acc_t                    s2_val_r;
  logic                    s2_neg_r;
  logic [ACC_W-1:0]        s2_ma_r;
  logic [SAMPLE_BITS-1:0]  s2_ms_r;
  // stage 3: product sum, clamp, write-back
  logic                    s3_v_r;
  item_t                   s3_r;
  acc_t                    s3_val_r;
  logic                    s3_neg_r;
  logic [PART_W-1:0]       s3_pl_r;
  logic [PART_W-1:0]       s3_ph_r;
  // result register
  logic                    out_v_r;
  acc_t                    out_val_r;
  logic                    out_last_r;

  logic s1_adv, s2_adv, s3_adv, s2_free, s3_free, o_free;

  acc_t                   samp;
  acc_t                   sum;
  logic                   sum_ovf;
  logic                   s_nz, a_nz;
  acc_t                   s1_val;
  logic                   s1_neg;
  logic [ACC_W-1:0]       s1_ma;
  logic [SAMPLE_BITS-1:0] s1_ms;
  logic [PART_W-1:0]      pl, ph;
  logic [PROD_W-1:0]      mag, limit;
  acc_t                   prod_val;
  acc_t                   s3_res;

  // elastic advance, back to front
  assign o_free  = !out_v_r || out_ready;
  assign s3_adv  = s3_v_r && (!s3_r.emit || o_free);
  assign s3_free = !s3_v_r || s3_adv;
  assign s2_adv  = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s2_adv;
  assign s1_adv  = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_adv;

  // any entry still in flight has not been written back yet
  assign chk_hit = (s1_v_r && s1_r.addr == chk_addr) ||
                   (s2_v_r && s2_r.addr == chk_addr) ||
                   (s3_v_r && s3_r.addr == chk_addr);

  always_comb begin
    samp    = ACC_W'(s1_r.sample);
    s_nz    = |s1_r.sample;
    a_nz    = |rd_data;
    sum     = rd_data + samp;
    sum_ovf = (rd_data[ACC_W-1] == samp[ACC_W-1]) && (sum[ACC_W-1] != rd_data[ACC_W-1]);
    s1_neg  = rd_data[ACC_W-1] ^ s1_r.sample[SAMPLE_BITS-1];
    s1_ma   = rd_data[ACC_W-1] ? (ACC_W'(0) - rd_data) : rd_data;
    s1_ms   = s1_r.sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - s1_r.sample) : s1_r.sample;
    if (s1_r.seed) begin
      s1_val = (s1_r.op == OP_AND || s1_r.op == OP_OR) ? ACC_W'(s_nz) : samp;
    end else begin
      case (s1_r.op)
        OP_MIN:  s1_val = (samp < rd_data) ? samp : rd_data;
        OP_MAX:  s1_val = (samp > rd_data) ? samp : rd_data;
        OP_AND:  s1_val = ACC_W'(a_nz && s_nz);
        OP_OR:   s1_val = ACC_W'(a_nz || s_nz);
        default: s1_val = sum_ovf ? (rd_data[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
      endcase
    end
  end

  assign pl = {{SAMPLE_BITS{1'b0}}, s2_ma_r[HALF_W-1:0]}     * {{HALF_W{1'b0}}, s2_ms_r};
  assign ph = {{SAMPLE_BITS{1'b0}}, s2_ma_r[ACC_W-1:HALF_W]} * {{HALF_W{1'b0}}, s2_ms_r};

  always_comb begin
    mag   = {s3_ph_r, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, s3_pl_r};
    limit = s3_neg_r ? {{SAMPLE_BITS{1'b0}}, ACC_MIN} : {{SAMPLE_BITS{1'b0}}, ACC_MAX};
    if (mag > limit) begin
      prod_val = s3_neg_r ? ACC_MIN : ACC_MAX;
    end else if (s3_neg_r) begin
      prod_val = ACC_W'(0) - mag[ACC_W-1:0];
    end else begin
      prod_val = mag[ACC_W-1:0];
    end
    s3_res = (s3_r.op == OP_PROD && !s3_r.seed) ? prod_val : s3_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r  <= ld;
      if (s2_free) s2_v_r  <= s1_adv;
      if (s3_free) s3_v_r  <= s2_adv;
      if (o_free)  out_v_r <= s3_adv && s3_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s1_r <= item;
    end
    if (s1_adv) begin
      s2_r     <= s1_r;
      s2_val_r <= s1_val;
      s2_neg_r <= s1_neg;
      s2_ma_r  <= s1_ma;
      s2_ms_r  <= s1_ms;
    end
    if (s2_adv) begin
      s3_r     <= s2_r;
      s3_val_r <= s2_val_r;
      s3_neg_r <= s2_neg_r;
      s3_pl_r  <= pl;
      s3_ph_r  <= ph;
    end
    if (o_free && s3_adv && s3_r.emit) begin
      out_val_r  <= s3_res;
      out_last_r <= s3_r.last;
    end
  end

  assign wr.en   = s3_adv;
  assign wr.addr = s3_r.addr;
  assign wr.data = s3_res;

  assign out_valid     = out_v_r;
  assign out_combined  = out_val_r;
  assign out_last_gate = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/cpi_pulse_combiner.sv
// Radar pulse integrator: top level with gate/pulse sequencer and config.
//
// Combines radar video across the pulses of a coherent processing interval,
// one range gate per word. Each word is the sample of the next gate of the
// current pulse; end_of_pulse closes the pulse. The first pulse of an
// interval seeds one 64-bit accumulator per gate in a line store of
// MAX_GATES entries and fixes the gate count; later pulses fold into it by
// combine_op (saturating sum or product, min, max, logical AND/OR of
// nonzero video), gates past the count being dropped. During the last
// pulse (cpi_span pulses, 0 read as 1) every folded gate is also issued as
// a result word; last_gate marks the final gate or the end of that pulse.
// Throughput is one word per clock while no gate is held off and the
// results are taken. From input accept to result valid, a word passes
// the line store read, whose data opens the first fold stage (operands
// and simple ops), then 32x16 partial products, then product sum and
// clamp with write-back, loading the result register. A gate whose
// accumulator is still inside the fold unit is held off until it has
// been written back, so pulses shorter than four gates run slower.
// The line store needs no clearing after reset; entries are seeded by the
// first pulse before any fold reads them. Write cpi_span and combine_op
// only while no words are in flight.
`default_nettype none

module cpi_pulse_combiner (
  input  logic                           clk,
  input  logic                           rst_n,
  // input video
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [cpc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                           in_end_of_pulse,
  // results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [cpc_pkg::ACC_W-1:0] out_combined,
  output logic                           out_last_gate,
  // configuration
  input  logic                           cfg_we,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpc_pkg::*;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic [GATE_W-1:0] gpos_r, gpos_nxt;    // next gate of this pulse
  logic [SPAN_W-1:0] ppos_r, ppos_nxt;    // pulse within the interval
  logic [GATE_W-1:0] gii_r, gii_nxt;      // gates set by the first pulse

  logic [SPAN_W-1:0] span_eff;
  logic [SPAN_W:0]   ppos_inc;
  logic              last_pulse;
  logic              in_range, seed, fold, do_write;
  logic [GATE_W-1:0] gpos_inc, gii_eff;
  logic              hazard, accept, ld;
  item_t             item;
  acc_t              rd_data;
  logic              chk_hit, s1_free;
  store_wr_t         wr;

  // ---- sequencer decode, from state alone so ready never looks at valid
  always_comb begin
    span_eff   = (span_r == '0) ? SPAN_W'(1) : span_r;
    ppos_inc   = {1'b0, ppos_r} + (SPAN_W+1)'(1);
    last_pulse = ppos_inc >= {1'b0, span_eff};
    in_range   = gpos_r < GATE_W'(MAX_GATES);
    gpos_inc   = gpos_r + GATE_W'(1);
    seed       = in_range && (ppos_r == '0);
    fold       = in_range && (ppos_r != '0) && (gpos_r < gii_r);
    do_write   = seed || fold;
    gii_eff    = seed ? gpos_inc : gii_r;
  end

  // a fold must not read an entry the fold unit has yet to write back
  assign hazard   = fold && chk_hit;
  assign in_ready = s1_free && !hazard;
  assign accept   = in_valid && in_ready;
  assign ld       = accept && do_write;

  always_comb begin
    item.addr   = gpos_r[ADDR_W-1:0];
    item.op     = decode_op(op_r);
    item.seed   = seed;
    item.emit   = last_pulse;
    item.last   = (gpos_inc == gii_eff) || in_end_of_pulse;
    item.sample = $signed(in_sample[SAMPLE_BITS-1:0]);
  end

  // ---- counters and config
  always_comb begin
    op_nxt   = op_r;
    span_nxt = span_r;
    gpos_nxt = gpos_r;
    ppos_nxt = ppos_r;
    gii_nxt  = gii_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COMBINE_OP: op_nxt   = cfg_data[OP_W-1:0];
        CFG_CPI_SPAN:   span_nxt = cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (seed) begin
        gii_nxt = gpos_inc;
      end
      if (in_end_of_pulse) begin
        gpos_nxt = '0;
        ppos_nxt = last_pulse ? '0 : ppos_inc[SPAN_W-1:0];
      end else if (in_range) begin
        gpos_nxt = gpos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_SUM;
      span_r <= SPAN_RESET;
      gpos_r <= '0;
      ppos_r <= '0;
      gii_r  <= '0;
    end else begin
      op_r   <= op_nxt;
      span_r <= span_nxt;
      gpos_r <= gpos_nxt;
      ppos_r <= ppos_nxt;
      gii_r  <= gii_nxt;
    end
  end

  cpc_line_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (ld),
    .rd_addr (item.addr),
    .rd_data (rd_data)
  );

  cpc_fold_pipe u_fold (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (ld),
    .item          (item),
    .rd_data       (rd_data),
    .chk_addr      (gpos_r[ADDR_W-1:0]),
    .chk_hit       (chk_hit),
    .s1_free       (s1_free),
    .wr            (wr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_combined  (out_combined),
    .out_last_gate (out_last_gate)
  );

endmodule

`default_nettype wire

FILE: rtl/cpc_port_checker.sv
// Port-level assertions for the pulse combiner, bound to the top level.
`default_nettype none

module cpc_port_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cpc_pkg::ACC_W-1:0]      out_combined,
  input logic                           out_last_gate,
  input logic                           cfg_we,
  input logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cpc_pkg::*;

  logic bin_mode_r;   // AND or OR selected

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COMBINE_OP) begin
        bin_mode_r <= (cfg_data[OP_W-1:0] == OP_AND) || (cfg_data[OP_W-1:0] == OP_OR);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_combined) && $stable(out_last_gate))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready straight after reset");

  a_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bin_mode_r |-> (out_combined == '0) || (out_combined == ACC_W'(1)))
    else $error("binary mode result not 0 or 1");

endmodule

bind cpi_pulse_combiner cpc_port_checker u_cpc_port_checker (.*);

`default_nettype wire

FILE: dv/cpi_pulse_combiner_tb.sv
// Self-checking testbench for the radar pulse combiner: directed script, then random intervals.
`default_nettype none

module cpi_pulse_combiner_tb;
  import cpc_pkg::*;

  localparam int unsigned LIMIT       = 1_000_000; // cycle budget for the whole run
  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned CALM_FROM    = 1700;     // no idling on either side past this
  localparam int unsigned SCRIPT_LEN   = 30;

  // One combined gate as it should leave the block.
  typedef struct {
    acc_t combined;
    logic last_gate;
  } gate_result_t;

  typedef enum logic {STEP_CFG, STEP_WORD} step_kind_t;

  // Directed script row: a register write or a video word, optionally with a typed result.
  typedef struct {
    step_kind_t kind;
    cfg_idx_t   idx;
    logic [6:0] data;
    logic signed [SAMPLE_W-1:0] sample;
    logic       eop;
    bit         pinned;
    acc_t       combined;
    logic       last_gate;
  } step_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid        = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample       = '0;
  logic                       in_end_of_pulse = 1'b0;
  logic                       out_valid;
  logic                       out_ready       = 1'b0;
  logic signed [ACC_W-1:0]    out_combined;
  logic                       out_last_gate;
  logic                       cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index       = '0;
  logic [CFG_DATA_W-1:0]      cfg_data        = '0;

  cpi_pulse_combiner uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_end_of_pulse (in_end_of_pulse),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_combined    (out_combined),
    .out_last_gate   (out_last_gate),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Integrator model: line store of per-gate accumulators plus the gate and
  // pulse counters, kept in step with every accepted word.
  // ---------------------------------------------------------------------------
  acc_t        acc_line [MAX_GATES];
  int unsigned pos_gate   = 0;
  int unsigned pos_pulse  = 0;
  int unsigned gate_count = 0;
  logic [2:0]  cur_op     = 3'd0;
  logic [6:0]  cur_span   = SPAN_RESET;

  gate_result_t results_due [$];

  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned words_random = 0;
  bit          calm         = 1'b0;   // suppresses idling on both sides
  int unsigned ready_hold   = 0;
  gate_result_t head_due;

  step_t script [SCRIPT_LEN];

  function automatic acc_t clamp_sum(acc_t a, acc_t v);
    logic signed [ACC_W:0] t;
    t = a + v;
    if (t[ACC_W] != t[ACC_W-1]) return t[ACC_W] ? ACC_MIN : ACC_MAX;
    return t[ACC_W-1:0];
  endfunction

  function automatic acc_t clamp_prod(acc_t a, acc_t v);
    logic signed [2*ACC_W-1:0] t;
    t = a * v;
    // anything outside the signed 64-bit range shows as a mismatch in the upper bits
    if (t[2*ACC_W-1:ACC_W-1] != {(ACC_W+1){t[2*ACC_W-1]}})
      return t[2*ACC_W-1] ? ACC_MIN : ACC_MAX;
    return t[ACC_W-1:0];
  endfunction

  function automatic acc_t seed_gate(acc_t v);
    if (cur_op == OP_AND || cur_op == OP_OR) return (v != 0) ? 64'sd1 : 64'sd0;
    return v;
  endfunction

  // Codes 6 and 7 fall through to a sum.
  function automatic acc_t fold_gate(acc_t a, acc_t v);
    case (cur_op)
      OP_PROD: return clamp_prod(a, v);
      OP_MIN:  return (v < a) ? v : a;
      OP_MAX:  return (v > a) ? v : a;
      OP_AND:  return (a != 0 && v != 0) ? 64'sd1 : 64'sd0;
      OP_OR:   return (a != 0 || v != 0) ? 64'sd1 : 64'sd0;
      default: return clamp_sum(a, v);
    endcase
  endfunction

  task automatic fold_word(input logic signed [SAMPLE_W-1:0] s, input logic eop,
                           output bit made, output gate_result_t r);
    acc_t        v;
    int unsigned span_eff, g, p;
    bit          last_pulse;
    v          = s;
    span_eff   = (cur_span == 0) ? 1 : cur_span;
    g          = pos_gate;
    p          = pos_pulse;
    last_pulse = (p + 1 >= span_eff);
    made       = 1'b0;
    r          = '{combined: '0, last_gate: 1'b0};
    if (g < MAX_GATES) begin
      if (p == 0) begin
        acc_line[g] = seed_gate(v);
        gate_count  = g + 1;
      end else if (g < gate_count) begin
        acc_line[g] = fold_gate(acc_line[g], v);
      end
      if (last_pulse && g < gate_count) begin
        made        = 1'b1;
        r.combined  = acc_line[g];
        // a short last pulse still closes the interval
        r.last_gate = (g + 1 == gate_count) || eop;
      end
    end
    if (eop) begin
      pos_gate  = 0;
      pos_pulse = last_pulse ? 0 : (p + 1) % 128;
    end else if (g < MAX_GATES) begin
      pos_gate = g + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] video_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      5:       return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offers one word, holds it until taken, then updates the model.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic eop,
                           input bit pinned, input acc_t pin_c, input logic pin_l);
    bit           made;
    gate_result_t r;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_end_of_pulse <= eop;
    do @(posedge clk); while (!in_ready);
    fold_word(s, eop, made, r);
    if (pinned) results_due.push_back('{combined: pin_c, last_gate: pin_l});
    else if (made) results_due.push_back(r);
  endtask

  // Stop sending, let every result out, then cover words still in the fold pipe.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input bit wr_op, input logic [6:0] op_data,
                              input bit wr_span, input logic [6:0] span_data);
    drain();
    if (wr_op) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_COMBINE_OP;
      cfg_data  <= op_data;
      @(posedge clk);
      cur_op = op_data[2:0];
    end
    if (wr_span) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_CPI_SPAN;
      cfg_data  <= span_data;
      @(posedge clk);
      cur_span = span_data;
    end
    cfg_we <= 1'b0;
  endtask

  function automatic step_t cfg_step(cfg_idx_t idx, logic [6:0] v);
    step_t st;
    st.kind = STEP_CFG;  st.idx = idx;  st.data = v;
    st.sample = '0;  st.eop = 1'b0;  st.pinned = 1'b0;  st.combined = '0;  st.last_gate = 1'b0;
    return st;
  endfunction

  function automatic step_t word_step(logic signed [SAMPLE_W-1:0] s, logic eop,
                                      bit pinned, acc_t c, logic l);
    step_t st;
    st.kind = STEP_WORD;  st.idx = CFG_COMBINE_OP;  st.data = '0;
    st.sample = s;  st.eop = eop;  st.pinned = pinned;  st.combined = c;  st.last_gate = l;
    return st;
  endfunction

  // Receiver: random stall bursts of random length.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every word out must match the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("result with nothing due: combined %0d last_gate %0b",
                   out_combined, out_last_gate);
        mismatches++;
      end else begin
        head_due = results_due.pop_front();
        if (out_combined !== head_due.combined || out_last_gate !== head_due.last_gate) begin
          if (mismatches < 10)
            $display("mismatch: combined exp %0d got %0d, last_gate exp %0b got %0b",
                     head_due.combined, out_combined, head_due.last_gate, out_last_gate);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned span_eff, gates, pulses, len, wr_sel, phase;
    logic [6:0]  span_v;
    logic [2:0]  op_v;
    bit          calm_phase;

    foreach (acc_line[i]) acc_line[i] = '0;

    script = '{
      // span 1: every word is seed and result at once, always closing the interval
      cfg_step(CFG_CPI_SPAN, 7'd1),
      word_step(16'sh7FFF, 1'b0, 1, 64'sd32767, 1'b1),
      word_step(16'sh8000, 1'b1, 1, -64'sd32768, 1'b1),
      // binary seed: nonzero reads as 1
      cfg_step(CFG_COMBINE_OP, {4'd0, OP_AND}),
      word_step(-16'sd1, 1'b0, 1, 64'sd1, 1'b1),
      word_step(16'sd0, 1'b1, 1, 64'sd0, 1'b1),
      // product clamps: (-2^15)^4 * -8 lands exactly on the floor, 32767^5 overflows
      cfg_step(CFG_COMBINE_OP, {4'd0, OP_PROD}),
      cfg_step(CFG_CPI_SPAN, 7'd5),
      word_step(16'sh8000, 1'b0, 0, '0, 1'b0),
      word_step(16'sh7FFF, 1'b1, 0, '0, 1'b0),
      word_step(16'sh8000, 1'b0, 0, '0, 1'b0),
      word_step(16'sh7FFF, 1'b1, 0, '0, 1'b0),
      word_step(16'sh8000, 1'b0, 0, '0, 1'b0),
      word_step(16'sh7FFF, 1'b1, 0, '0, 1'b0),
      word_step(16'sh8000, 1'b0, 0, '0, 1'b0),
      word_step(16'sh7FFF, 1'b1, 0, '0, 1'b0),
      word_step(-16'sd8, 1'b0, 1, ACC_MIN, 1'b0),
      word_step(16'sh7FFF, 1'b1, 1, ACC_MAX, 1'b1),
      // max with a short last pulse: 3 gates seeded, only 2 folded
      cfg_step(CFG_COMBINE_OP, {4'd0, OP_MAX}),
      cfg_step(CFG_CPI_SPAN, 7'd2),
      word_step(16'sd5, 1'b0, 0, '0, 1'b0),
      word_step(-16'sd7, 1'b0, 0, '0, 1'b0),
      word_step(16'sd1, 1'b1, 0, '0, 1'b0),
      word_step(16'sd9, 1'b0, 1, 64'sd9, 1'b0),
      word_step(-16'sd9, 1'b1, 1, -64'sd7, 1'b1),
      // operator switched mid interval, then an extra gate past the count
      cfg_step(CFG_COMBINE_OP, {4'd0, OP_MIN}),
      word_step(16'sd3, 1'b1, 0, '0, 1'b0),
      cfg_step(CFG_COMBINE_OP, {4'd0, OP_OR}),
      word_step(16'sd0, 1'b0, 1, 64'sd1, 1'b1),
      word_step(16'sd4, 1'b1, 0, '0, 1'b0)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG)
        program_regs(script[i].idx == CFG_COMBINE_OP, script[i].data,
                     script[i].idx == CFG_CPI_SPAN, script[i].data);
      else
        send_word(script[i].sample, script[i].eop, script[i].pinned,
                  script[i].combined, script[i].last_gate);
    end

    // Random intervals. Early phases pin the span extremes and the unused op codes.
    for (phase = 0; words_random < RANDOM_WORDS; phase++) begin
      calm_phase = ($urandom_range(0, 4) == 0);

      case (phase)
        0:       span_v = 7'd64;
        1:       span_v = 7'd0;
        2:       span_v = 7'd127;
        default: span_v = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(2, 4))
                                                      : 7'($urandom_range(1, 8));
      endcase
      case (phase)
        1:       op_v = 3'd6;
        2:       op_v = 3'd7;
        default: op_v = 3'($urandom_range(0, 7));
      endcase
      // spare upper bits of the op write must be ignored
      wr_sel = (phase < 3) ? 2 : $urandom_range(0, 7);
      program_regs(wr_sel != 1, {4'($urandom_range(0, 15)), op_v}, wr_sel != 0, span_v);

      span_eff = (cur_span == 0) ? 1 : cur_span;
      if (span_eff >= 32)
        gates = $urandom_range(1, 3);
      else
        gates = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 10);
      pulses = span_eff * ((span_eff >= 32) ? 1 : $urandom_range(1, 3));
      // sometimes stop mid interval so the next setting lands inside it
      if ($urandom_range(0, 4) == 0) pulses = $urandom_range(1, pulses);

      for (int pn = 0; pn < pulses; pn++) begin
        if (words_random >= RANDOM_WORDS) break;
        calm <= calm_phase || (words_random >= CALM_FROM);
        len = gates;
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, gates);
          1:       len = gates + $urandom_range(1, 3);
          default: ;
        endcase
        for (int i = 0; i < len; i++)
          send_word(video_sample(), i == len - 1, 0, '0, 1'b0);
        words_random += len;
      end
    end

    drain();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
